// ----- hw/rtl/sawc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sawc_pkg: shared types and constants for the serial adc word capture block
// register indexes, configuration bundle, result beat layout and word sizing
// ----------------------------------------------------------------------------
package sawc_pkg;

  localparam int MaxWordBits = 50;
  localparam int MinWordBits = 7;
  localparam int RegIdxW     = 2;
  localparam int AddrW       = RegIdxW + 2;
  localparam int DataW       = 32;

  typedef enum logic [RegIdxW-1:0] {
    RegWordSize   = 2'd0,
    RegWordCount  = 2'd1,
    RegHalfPeriod = 2'd2,
    RegGapTicks   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [5:0]  word_size_bits;
    logic [15:0] word_count;
    logic [7:0]  half_period_ticks;
    logic [15:0] gap_ticks;
  } cfg_t;

  // field order from the lowest bit up: chip_enable, serial_clock, word_valid,
  // word_value, run_done, busy_res
  typedef struct packed {
    logic                   busy_res;
    logic                   run_done;
    logic [MaxWordBits-1:0] word_value;
    logic                   word_valid;
    logic                   serial_clock;
    logic                   chip_enable;
  } res_t;

  // clamp the programmed word size into the supported range
  function automatic logic [5:0] eff_word_size(input logic [5:0] w);
    logic [5:0] r;
    r = w;
    if (w < 6'(MinWordBits)) r = 6'(MinWordBits);
    if (w > 6'(MaxWordBits)) r = 6'(MaxWordBits);
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/serial_adc_word_capture.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// serial_adc_word_capture: serial converter reader driven by tick beats
// each input beat (start or tick) yields exactly one result beat that carries
// the pin levels and, when a word completes, the captured word
// ----------------------------------------------------------------------------
// output: each result beat is registered, in the output register or, while the
//   output stalls, in the skid entry
// throughput: one beat per cycle while the skid entry is free; the sequencer
//   update is a single pass of counter compare and shift logic, and a skid stage
//   keeps input open while a result waits
// reset: synchronous rst returns the sequencer to idle with pins low and the
//   registers to word size 16, count 1, half period 1, gap 0
module serial_adc_word_capture import sawc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // input beats
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // [0] data_bit, [7:1] zero
  input  wire logic              s_tuser,   // [0] func: 0 start run, 1 tick
  // result beats
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [55:0]            m_tdata,   // [0] chip_enable, [1] serial_clock,
                                            // [51:2] word_value, [52] busy_res,
                                            // [55:53] zero
  output logic                   m_tuser,   // [0] word_valid
  output logic                   m_tlast,   // run_done
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]       prdata,
  output logic                   pready
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     reg_wr;

  res_t core_res;
  logic in_accept;

  // output register plus one skid entry
  res_t out_res;
  logic out_valid;
  res_t skid_res;
  logic skid_valid;

  // ---------------------------------------------------------------------
  // register file, always ready, word aligned registers
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[AddrW-1:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.word_size_bits    <= 6'd16;
      cfg.word_count        <= 16'd1;
      cfg.half_period_ticks <= 8'd1;
      cfg.gap_ticks         <= 16'd0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        RegWordSize:   cfg.word_size_bits    <= pwdata[5:0];
        RegWordCount:  cfg.word_count        <= pwdata[15:0];
        RegHalfPeriod: cfg.half_period_ticks <= pwdata[7:0];
        RegGapTicks:   cfg.gap_ticks         <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (reg_idx)
      RegWordSize:   prdata = {26'd0, cfg.word_size_bits};
      RegWordCount:  prdata = {16'd0, cfg.word_count};
      RegHalfPeriod: prdata = {24'd0, cfg.half_period_ticks};
      RegGapTicks:   prdata = {16'd0, cfg.gap_ticks};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // sequencer: state advances on every accepted beat
  // ---------------------------------------------------------------------
  assign s_tready  = !skid_valid;
  assign in_accept = s_tvalid && s_tready;

  sawc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (in_accept),
    .func     (s_tuser),
    .data_bit (s_tdata[0]),
    .cfg      (cfg),
    .res      (core_res)
  );

  // ---------------------------------------------------------------------
  // result beat buffering: skid entry fills only while the output stalls
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_res   <= core_res;
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_res   <= core_res;
      skid_valid <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, out_res.busy_res, out_res.word_value,
                     out_res.serial_clock, out_res.chip_enable};
  assign m_tuser  = out_res.word_valid;
  assign m_tlast  = out_res.run_done;

`ifndef SYNTHESIS
  a_skid_only_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a beat while output is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    (in_accept && out_valid && !m_tready) |=> skid_valid)
    else $error("accepted beat lost during output stall");

  a_no_accept_when_skid: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !in_accept)
    else $error("beat accepted with skid entry occupied");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/sawc_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sawc_core: capture sequencer
// advances the enable / clock pin state and the word shifter by one start or tick beat
// ----------------------------------------------------------------------------
module sawc_core import sawc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire logic func,
  input  wire logic data_bit,
  input  wire cfg_t cfg,
  output res_t      res
);

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhSetup = 3'd1,
    PhHigh  = 3'd2,
    PhLow   = 3'd3,
    PhGap   = 3'd4
  } phase_t;

  phase_t                 phase, phase_next;
  logic [15:0]            tick_counter, tick_counter_next;
  logic [5:0]             bit_counter, bit_counter_next;
  logic [15:0]            words_done, words_done_next;
  logic [MaxWordBits-1:0] shift_word, shift_word_next;
  logic                   enable_level, enable_level_next;
  logic                   clock_level, clock_level_next;

  logic [7:0]  half;
  logic [15:0] tick_inc;
  logic        half_hit;
  logic [15:0] words_inc;
  logic        do_sample;
  logic        do_begin;
  logic        word_valid;
  logic        run_done;

  always_comb begin
    half              = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
    tick_inc          = tick_counter + 16'd1;
    half_hit          = tick_inc >= {8'd0, half};
    words_inc         = words_done + 16'd1;
    phase_next        = phase;
    tick_counter_next = tick_counter;
    bit_counter_next  = bit_counter;
    words_done_next   = words_done;
    shift_word_next   = shift_word;
    enable_level_next = enable_level;
    clock_level_next  = clock_level;
    do_sample         = 1'b0;
    do_begin          = 1'b0;
    word_valid        = 1'b0;
    run_done          = 1'b0;

    if (!func) begin
      if (phase == PhIdle && cfg.word_count != 16'd0) begin
        words_done_next = 16'd0;
        do_begin        = 1'b1;
      end
    end else begin
      unique case (phase)
        PhSetup: begin
          tick_counter_next = tick_inc;
          if (half_hit) do_sample = 1'b1;
        end
        PhHigh: begin
          tick_counter_next = tick_inc;
          if (half_hit) begin
            clock_level_next  = 1'b0;
            phase_next        = PhLow;
            tick_counter_next = 16'd0;
          end
        end
        PhLow: begin
          tick_counter_next = tick_inc;
          if (half_hit) begin
            if (bit_counter < eff_word_size(cfg.word_size_bits)) begin
              do_sample = 1'b1;
            end else begin
              enable_level_next = 1'b0;
              word_valid        = 1'b1;
              words_done_next   = words_inc;
              tick_counter_next = 16'd0;
              if (words_inc >= cfg.word_count) begin
                run_done   = 1'b1;
                phase_next = PhIdle;
              end else begin
                phase_next = PhGap;
              end
            end
          end
        end
        PhGap: begin
          if (tick_counter >= cfg.gap_ticks) do_begin = 1'b1;
          else tick_counter_next = tick_inc;
        end
        default: ;
      endcase
    end

    // sample one bit msb first and raise the serial clock
    if (do_sample) begin
      shift_word_next   = {shift_word[MaxWordBits-2:0], data_bit};
      bit_counter_next  = bit_counter + 6'd1;
      clock_level_next  = 1'b1;
      phase_next        = PhHigh;
      tick_counter_next = 16'd0;
    end

    // open a new word: enable high, setup interval starts
    if (do_begin) begin
      enable_level_next = 1'b1;
      clock_level_next  = 1'b0;
      bit_counter_next  = 6'd0;
      shift_word_next   = '0;
      tick_counter_next = 16'd0;
      phase_next        = PhSetup;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PhIdle;
      tick_counter <= 16'd0;
      bit_counter  <= 6'd0;
      words_done   <= 16'd0;
      shift_word   <= '0;
      enable_level <= 1'b0;
      clock_level  <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      tick_counter <= tick_counter_next;
      bit_counter  <= bit_counter_next;
      words_done   <= words_done_next;
      shift_word   <= shift_word_next;
      enable_level <= enable_level_next;
      clock_level  <= clock_level_next;
    end
  end

  always_comb begin
    res.chip_enable  = enable_level_next;
    res.serial_clock = clock_level_next;
    res.word_valid   = word_valid;
    res.word_value   = word_valid ? shift_word : '0;
    res.run_done     = run_done;
    res.busy_res     = phase_next != PhIdle;
  end

`ifndef SYNTHESIS
  a_clock_needs_enable: assert property (@(posedge clk) disable iff (rst)
    clock_level |-> enable_level)
    else $error("serial clock high while enable low");

  a_idle_lines_low: assert property (@(posedge clk) disable iff (rst)
    (phase == PhIdle) |-> (!enable_level && !clock_level))
    else $error("pins active while idle");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_counter <= 6'(MaxWordBits))
    else $error("bit counter beyond word size");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    (step && res.run_done) |-> (res.word_valid && !res.busy_res && !res.chip_enable))
    else $error("run end without finished word");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_serial_adc_word_capture.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_serial_adc_word_capture: regression bench for the serial adc word capture
// drives start and tick beats under random flow control, tracks the capture
// sequencer in a local model and checks every result beat field by field;
// registers go through the apb port with read-back while the stream is drained
// ----------------------------------------------------------------------------
module tb_serial_adc_word_capture;
  import sawc_pkg::*;

  // input beat kinds carried on s_tuser
  localparam logic FuncStart = 1'b0;
  localparam logic FuncTick  = 1'b1;

  // random part length and a generous run limit in time units
  localparam int          RandomBeats = 300;
  localparam longint      RunLimit    = 80_000_000;

  // sequencer phases of the local model
  typedef enum logic [2:0] {PhIdle, PhSetup, PhHigh, PhLow, PhGap} cap_phase_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  wire logic         s_tready;
  logic [7:0]        s_tdata = '0;   // [0] data_bit, [7:1] zero
  logic              s_tuser = 1'b0; // [0] func
  wire logic         m_tvalid;
  logic              m_tready = 1'b0;
  wire logic [55:0]  m_tdata;        // [0] chip_enable, [1] serial_clock,
                                     // [51:2] word_value, [52] busy_res
  wire logic         m_tuser;        // [0] word_valid
  wire logic         m_tlast;        // run_done
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  wire logic [DataW-1:0] prdata;
  wire logic         pready;

  // local copy of the registers
  logic [5:0]  cfg_word_size   = 6'd16;
  logic [15:0] cfg_word_count  = 16'd1;
  logic [7:0]  cfg_half_period = 8'd1;
  logic [15:0] cfg_gap_ticks   = 16'd0;

  // local copy of the sequencer state
  cap_phase_t             cap_phase      = PhIdle;
  int unsigned            cap_ticks      = 0;
  logic [5:0]             cap_bits       = '0;
  logic [15:0]            cap_words_done = '0;
  logic [MaxWordBits-1:0] cap_shift      = '0;
  logic                   cap_enable     = 1'b0;
  logic                   cap_sclk       = 1'b0;

  res_t expected_beats[$];
  res_t oldest_expect;
  int   fail_count = 0;
  int   beats_sent = 0;
  int   burst_left = 0;

  serial_adc_word_capture dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // capture model
  // ---------------------------------------------------------------------------

  // enable rises and a fresh word begins with the setup interval
  function automatic void open_word();
    cap_enable = 1'b1;
    cap_sclk   = 1'b0;
    cap_bits   = '0;
    cap_shift  = '0;
    cap_ticks  = 0;
    cap_phase  = PhSetup;
  endfunction

  // shift in one bit msb first and raise the clock
  function automatic void take_bit(input logic data_bit);
    cap_shift = {cap_shift[MaxWordBits-2:0], data_bit};
    cap_bits  = cap_bits + 6'd1;
    cap_sclk  = 1'b1;
    cap_phase = PhHigh;
    cap_ticks = 0;
  endfunction

  // advance the model by one accepted beat and return the beat it must produce
  function automatic res_t capture_step(input logic func, input logic data_bit);
    res_t        r;
    int unsigned half;
    int unsigned size;
    r    = '0;
    half = (cfg_half_period == 8'd0) ? 1 : int'(cfg_half_period);
    size = int'(cfg_word_size);
    if (size < MinWordBits) size = MinWordBits;
    if (size > MaxWordBits) size = MaxWordBits;
    if (func == FuncStart) begin
      // a start only counts while idle and with a nonzero count
      if (cap_phase == PhIdle && cfg_word_count != 16'd0) begin
        cap_words_done = '0;
        open_word();
      end
    end else begin
      case (cap_phase)
        PhSetup: begin
          cap_ticks++;
          if (cap_ticks >= half) take_bit(data_bit);
        end
        PhHigh: begin
          cap_ticks++;
          if (cap_ticks >= half) begin
            cap_sclk  = 1'b0;
            cap_phase = PhLow;
            cap_ticks = 0;
          end
        end
        PhLow: begin
          cap_ticks++;
          if (cap_ticks >= half) begin
            if (int'(cap_bits) < size) begin
              take_bit(data_bit);
            end else begin
              // word finished: enable drops and the word goes out
              cap_enable     = 1'b0;
              r.word_valid   = 1'b1;
              r.word_value   = cap_shift;
              cap_words_done = cap_words_done + 16'd1;
              cap_ticks      = 0;
              if (cap_words_done >= cfg_word_count) begin
                r.run_done = 1'b1;
                cap_phase  = PhIdle;
              end else begin
                cap_phase = PhGap;
              end
            end
          end
        end
        PhGap: begin
          if (cap_ticks >= int'(cfg_gap_ticks)) open_word();
          else cap_ticks = (cap_ticks + 1) & 32'hFFFF;
        end
        default: begin
        end
      endcase
    end
    r.chip_enable  = cap_enable;
    r.serial_clock = cap_sclk;
    r.busy_res     = (cap_phase != PhIdle);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checking
  // ---------------------------------------------------------------------------

  // receiver alternates between always ready, coin flips, mostly ready and
  // long stretches of heavy stalling
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 7) != 0);
          default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // each accepted result beat is matched against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with no expectation waiting");
        fail_count++;
      end else begin
        oldest_expect = expected_beats.pop_front();
        check_field("chip_enable", 64'(oldest_expect.chip_enable), 64'(m_tdata[0]));
        check_field("serial_clock", 64'(oldest_expect.serial_clock), 64'(m_tdata[1]));
        check_field("word_valid", 64'(oldest_expect.word_valid), 64'(m_tuser));
        check_field("word_value", 64'(oldest_expect.word_value), 64'(m_tdata[51:2]));
        check_field("run_done", 64'(oldest_expect.run_done), 64'(m_tlast));
        check_field("busy_res", 64'(oldest_expect.busy_res), 64'(m_tdata[52]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side and register access
  // ---------------------------------------------------------------------------

  // send one beat; the sender works in bursts with random idle gaps between
  task automatic send_beat(input logic func, input logic data_bit);
    int gap_len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_len > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {7'd0, data_bit};
    do @(posedge clk); while (!s_tready);
    // beat accepted at this edge
    expected_beats.push_back(capture_step(func, data_bit));
    burst_left--;
    beats_sent++;
  endtask

  // hold the sender off until every expected result beat has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // apb write followed by a read-back of the same register
  task automatic reg_write(input reg_idx_t idx, input logic [DataW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      RegWordSize:   cfg_word_size   = value[5:0];
      RegWordCount:  cfg_word_count  = value[15:0];
      RegHalfPeriod: cfg_half_period = value[7:0];
      default:       cfg_gap_ticks   = value[15:0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // prdata sampled with the access phase still in place
    check_field("prdata", 64'(value), 64'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [5:0] size, input logic [15:0] count,
                            input logic [7:0] half, input logic [15:0] gap);
    drain_results();
    reg_write(RegWordSize, DataW'(size));
    reg_write(RegWordCount, DataW'(count));
    reg_write(RegHalfPeriod, DataW'(half));
    reg_write(RegGapTicks, DataW'(gap));
  endtask

  // one capture run: a start, then ticks with random data until the run ends;
  // start_pct percent of the beats during the run are stray starts
  task automatic run_capture(input int start_pct);
    send_beat(FuncStart, 1'($urandom_range(0, 1)));
    while (cap_phase != PhIdle) begin
      send_beat(($urandom_range(0, 99) < start_pct) ? FuncStart : FuncTick,
                1'($urandom_range(0, 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // ticks while idle leave every line low
  task automatic test_idle_ticks();
    send_beat(FuncTick, 1'b0);
    send_beat(FuncTick, 1'b1);
  endtask

  // a start with a zero word count is ignored
  task automatic test_zero_count();
    set_config(6'd16, 16'd0, 8'd1, 16'd0);
    send_beat(FuncStart, 1'b1);
    send_beat(FuncTick, 1'b0);
  endtask

  // word size below range clamps to seven, half period zero acts as one,
  // and a start in the middle of the run is ignored
  task automatic test_clamped_run();
    set_config(6'd0, 16'd1, 8'd0, 16'd0);
    send_beat(FuncStart, 1'b0);
    repeat (3) send_beat(FuncTick, 1'($urandom_range(0, 1)));
    send_beat(FuncStart, 1'b1);
    while (cap_phase != PhIdle) send_beat(FuncTick, 1'($urandom_range(0, 1)));
  endtask

  // a maximum-count run cut short by lowering word_count below words done;
  // the next finished word must carry run_done
  task automatic test_count_cut();
    set_config(6'($urandom_range(7, 9)), 16'hFFFF, 8'd1, 16'd0);
    send_beat(FuncStart, 1'b0);
    while (cap_words_done < 16'd3) send_beat(FuncTick, 1'($urandom_range(0, 1)));
    drain_results();
    reg_write(RegWordCount, DataW'(1));
    while (cap_phase != PhIdle) send_beat(FuncTick, 1'($urandom_range(0, 1)));
  endtask

  // register extremes: oversized word, widest word, long half period,
  // long gap between words
  task automatic test_extreme_settings();
    set_config(6'd63, 16'd1, 8'd1, 16'd2);
    run_capture(0);
    set_config(6'd50, 16'd1, 8'd2, 16'd0);
    run_capture(0);
    set_config(6'd7, 16'd1, 8'd10, 16'd0);
    run_capture(0);
    set_config(6'd7, 16'd2, 8'd1, 16'd60);
    run_capture(0);
  endtask

  // random settings per phase, well-formed runs with random data, some
  // stray starts and idle ticks as noise
  task automatic test_random_runs();
    int          first_beat;
    int          pick;
    logic [5:0]  size;
    logic [15:0] count;
    logic [7:0]  half;
    logic [15:0] gap;
    first_beat = beats_sent;
    while (beats_sent - first_beat < RandomBeats) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      size = 6'($urandom_range(7, 14));
      else if (pick < 80) size = 6'($urandom_range(0, 6));
      else if (pick < 92) size = 6'($urandom_range(15, 30));
      else                size = 6'($urandom_range(31, 63));
      count = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
      half  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 12))
                                          : 8'($urandom_range(0, 3));
      gap   = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3))
                                         : 16'($urandom_range(4, 40));
      set_config(size, count, half, gap);
      // a few settings run back to back before the next change
      repeat ($urandom_range(1, 3)) begin
        run_capture(3);
        repeat ($urandom_range(0, 2)) send_beat(FuncTick, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_ticks();
    test_zero_count();
    test_clamped_run();
    test_count_cut();
    test_extreme_settings();
    test_random_runs();
    // let any stray beat show up after the last expectation
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("serial_adc_word_capture regression: pass");
    end else begin
      $display("serial_adc_word_capture regression: fail");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #(RunLimit);
    $display("serial_adc_word_capture regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
